@@ hdl/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, sizes and constants of the sectored history ring store.
// ----------------------------------------------------------------------------
package shs_pkg;

   // ring geometry (store depth and sector size are powers of two, so the
   // slot of a record is the low bits of its running record number)
   localparam int SECTOR_COUNT       = 4;
   localparam int RECORDS_PER_SECTOR = 512;
   localparam int RING_CAPACITY      = 1536;
   localparam int MAX_ROWS           = 16;

   localparam int STORE_DEPTH = SECTOR_COUNT * RECORDS_PER_SECTOR;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam int SECT_LSB    = $clog2(RECORDS_PER_SECTOR);

   // field widths
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 16;
   localparam int TIME_W   = 32;
   localparam int INDEX_W  = 11;
   localparam int PAGE_W   = 16;
   localparam int ROWS_W   = 5;
   localparam int STAMP_W  = 23;
   localparam int COUNT_W  = 11;
   localparam int TAG_W    = TIME_W - SECT_LSB;

   // page count divider: numerator is available + rows - 1
   localparam int NUMER_W   = $clog2(RING_CAPACITY + MAX_ROWS);
   localparam int DIV_CNT_W = $clog2(NUMER_W + 1);

   // page offset (page - 1) * rows, and offset plus row
   localparam int BASE_W = COUNT_W + ROWS_W;
   localparam int BACK_W = BASE_W + 1;

   // milliseconds to seconds by reciprocal multiply: q = (x * M) >> 38
   localparam int               HALF_W        = TIME_W / 2;
   localparam int               MAGIC_W       = 29;
   localparam logic [MAGIC_W-1:0] DIV1000_MAGIC = 29'd274877907;
   localparam int               DIV1000_SHIFT = 38;
   localparam int               PROD_W        = HALF_W + MAGIC_W;
   localparam int               SUM_W         = PROD_W + HALF_W;

   localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOG  = 2'd0,
      OP_READ = 2'd1,
      OP_PAGE = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_CHK,
      ST_LOG_WR,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_EMIT,
      ST_PG_SETUP,
      ST_PG_ADDR,
      ST_PG_DATA
   } state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  sample_value;
      logic [TIME_W-1:0]   now_ms;
      logic [INDEX_W-1:0]  record_index;
      logic [PAGE_W-1:0]   page_number;
      logic [ROWS_W-1:0]   rows_per_page;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [STAMP_W-1:0] stamp_seconds;
      logic [VALUE_W-1:0] record_value;
      logic [COUNT_W-1:0] available_count;
      logic [COUNT_W-1:0] pages_total;
      logic               final_row;
   } rsp_type;

   // one stored record: sector pass tag, stamp and sample
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
      logic [VALUE_W-1:0] value;
   } rec_type;

endpackage

@@ hdl/shs_ram.sv @@
// ----------------------------------------------------------------------------
// shs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/shs_pgdiv.sv @@
// ----------------------------------------------------------------------------
// shs_pgdiv
// Bit-serial restoring divider for the page count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module shs_pgdiv (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [shs_pkg::NUMER_W-1:0]    numer,
   input  logic [shs_pkg::ROWS_W-1:0]     denom,
   output logic                           done,
   output logic [shs_pkg::NUMER_W-1:0]    quot
);
   import shs_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUMER_W-1:0]   quot_ff;
   logic [ROWS_W-1:0]    rem_ff;
   logic [ROWS_W-1:0]    den_ff;
   logic [ROWS_W:0]      trial;
   logic                 fits;

   // shift next numerator bit into the partial remainder
   always_comb begin
      trial = {rem_ff, quot_ff[NUMER_W-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(NUMER_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: numerator shifts out as quotient shifts in
   always_ff @(posedge clock) begin
      if (go) begin
         quot_ff <= numer;
         rem_ff  <= '0;
         den_ff  <= denom;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NUMER_W-2:0], fits};
         rem_ff  <= fits ? ROWS_W'(trial - {1'b0, den_ff}) : trial[ROWS_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hdl/sectored_history_ring_store.sv @@
// ----------------------------------------------------------------------------
// sectored_history_ring_store
// Time-stamped sample log in a ring of sectors, with record and page reads.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low, and busy stays high
// until the last result has been put out. Every result is on rsp_data for one
// cycle with rsp_strobe high and must be taken then; there is no back-pressure.
// The last result is on rsp_data in the cycle that busy falls. Every command
// runs the bit-serial page-count divider (one quotient bit a cycle). A dropped
// log skips the record write, and an out-of-range record read skips the record
// RAM's registered read port, which a page read uses once per row. Records
// live in one RAM with a sector pass tag next to each entry, so a sector clear
// costs nothing and no clearing pass is run after reset: the block is ready
// right away.
// ----------------------------------------------------------------------------
module sectored_history_ring_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  shs_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output shs_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [shs_pkg::TIME_W-1:0]      csr_wdata
);
   import shs_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  period_ff;
   logic [TIME_W-1:0]  total_ff;
   logic [TIME_W-1:0]  last_ms_ff;
   logic               rsp_strobe_ff;
   logic               pend_valid_ff;

   // payload state
   req_type            req_ff;
   logic [ROWS_W-1:0]  rows_ff;
   logic [PROD_W-1:0]  pl_ff, ph_ff;
   logic               res_ok_ff;
   logic [STAMP_W-1:0] res_stamp_ff;
   logic [VALUE_W-1:0] res_value_ff;
   logic [COUNT_W-1:0] pages_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [ROWS_W-1:0]  row_ff;
   logic [TAG_W-1:0]   rd_tag_ff;
   logic [STAMP_W-1:0] pend_stamp_ff;
   logic [VALUE_W-1:0] pend_value_ff;
   rsp_type            rsp_ff;

   // datapath nets
   logic [ROWS_W-1:0]  rows_clamped;
   logic [COUNT_W-1:0] avail;
   logic [TIME_W-1:0]  delta_ms;
   logic               drop;
   logic [SUM_W-1:0]   stamp_sum;
   logic [STAMP_W-1:0] stamp_now;
   logic [TIME_W-1:0]  g_read;
   logic [TIME_W-1:0]  g_page;
   logic               rd_in_range;
   logic [COUNT_W-1:0] page_clamped;
   logic [BACK_W-1:0]  back;
   logic               page_stop;
   logic [NUMER_W-1:0] div_numer;
   logic [NUMER_W-1:0] div_quot;
   logic               div_done;
   rec_type            wr_rec;
   rec_type            rd_rec;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [TAG_W-1:0]   rd_tag_in;
   logic               hit;

   // control outputs of the sequencer
   logic               div_go;
   logic               ram_we;
   logic               ram_re;
   logic               emit;
   logic               emit_ok;
   logic [STAMP_W-1:0] emit_stamp;
   logic [VALUE_W-1:0] emit_value;
   logic               emit_final;

   // rows per page: zero reads as one, large values clamp to the maximum
   always_comb begin
      rows_clamped = req_data.rows_per_page;
      if (rows_clamped == '0) begin
         rows_clamped = ROWS_W'(1);
      end else if (rows_clamped > ROWS_W'(MAX_ROWS)) begin
         rows_clamped = ROWS_W'(MAX_ROWS);
      end
   end

   // records available, capped at ring capacity
   assign avail = (total_ff > TIME_W'(RING_CAPACITY)) ? COUNT_W'(RING_CAPACITY)
                                                      : total_ff[COUNT_W-1:0];

   // log throttle, skipped while nothing is logged
   assign delta_ms = req_ff.now_ms - last_ms_ff;
   assign drop     = (total_ff != '0) && (delta_ms < period_ff);

   // seconds from the two registered partial products
   assign stamp_sum = (SUM_W'(ph_ff) << HALF_W) + SUM_W'(pl_ff);
   assign stamp_now = stamp_sum[DIV1000_SHIFT +: STAMP_W];

   // running record numbers of the read target and of the current page row
   assign rd_in_range = (COUNT_W'(req_ff.record_index) < avail);
   assign g_read      = total_ff - TIME_W'(avail) + TIME_W'(req_ff.record_index);
   assign back        = BACK_W'(base_ff) + BACK_W'(row_ff);
   assign g_page      = total_ff - TIME_W'(1) - TIME_W'(back);
   assign page_stop   = (row_ff == rows_ff) || (back >= BACK_W'(avail));

   // page number clamped into 1 .. pages_total
   always_comb begin
      if (req_ff.page_number == '0) begin
         page_clamped = COUNT_W'(1);
      end else if (req_ff.page_number > PAGE_W'(pages_ff)) begin
         page_clamped = pages_ff;
      end else begin
         page_clamped = req_ff.page_number[COUNT_W-1:0];
      end
   end

   // divider feed: ceil(available / rows)
   assign div_numer = NUMER_W'(avail) + NUMER_W'(rows_ff) - NUMER_W'(1);

   // record RAM ports
   assign wr_rec.tag   = total_ff[TIME_W-1:SECT_LSB];
   assign wr_rec.stamp = stamp_now;
   assign wr_rec.value = req_ff.sample_value;
   assign ram_raddr = (state_ff == ST_RD_ADDR) ? g_read[SLOT_W-1:0] : g_page[SLOT_W-1:0];
   assign rd_tag_in = (state_ff == ST_RD_ADDR) ? g_read[TIME_W-1:SECT_LSB]
                                               : g_page[TIME_W-1:SECT_LSB];
   // entry holds this record only if written in the same sector pass
   assign hit = (rd_rec.tag == rd_tag_ff);

   shs_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (STORE_DEPTH)
   ) u_rec_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (total_ff[SLOT_W-1:0]),
      .wdata (wr_rec),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_rec)
   );

   shs_pgdiv u_pgdiv (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .numer (div_numer),
      .denom (rows_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.opcode == OP_LOG) ? ST_LOG_CHK : ST_DIV_GO;
            end
         end
         ST_LOG_CHK:  state_in = drop ? ST_DIV_GO : ST_LOG_WR;
         ST_LOG_WR:   state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (req_ff.opcode == OP_READ) begin
                  state_in = ST_RD_ADDR;
               end else if (req_ff.opcode == OP_PAGE) begin
                  state_in = ST_PG_SETUP;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RD_ADDR:  state_in = rd_in_range ? ST_RD_DATA : ST_EMIT;
         ST_RD_DATA:  state_in = ST_EMIT;
         ST_EMIT:     state_in = ST_IDLE;
         ST_PG_SETUP: state_in = ST_PG_ADDR;
         ST_PG_ADDR:  state_in = page_stop ? ST_IDLE : ST_PG_DATA;
         ST_PG_DATA:  state_in = hit ? ST_PG_ADDR : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      div_go     = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      emit       = 1'b0;
      emit_ok    = 1'b0;
      emit_stamp = pend_stamp_ff;
      emit_value = pend_value_ff;
      emit_final = 1'b1;
      case (state_ff)
         ST_LOG_WR:  ram_we = 1'b1;
         ST_DIV_GO:  div_go = 1'b1;
         ST_RD_ADDR: ram_re = rd_in_range;
         ST_EMIT: begin
            emit       = 1'b1;
            emit_ok    = res_ok_ff;
            emit_stamp = res_stamp_ff;
            emit_value = res_value_ff;
         end
         ST_PG_ADDR: begin
            if (page_stop) begin
               // close the page with the held row, or an empty result
               emit    = 1'b1;
               emit_ok = pend_valid_ff;
            end else begin
               ram_re = 1'b1;
            end
         end
         ST_PG_DATA: begin
            if (hit) begin
               // another row exists, so the held one is not the last
               emit       = pend_valid_ff;
               emit_ok    = 1'b1;
               emit_final = 1'b0;
            end else begin
               emit    = 1'b1;
               emit_ok = pend_valid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= PERIOD_RESET;
         total_ff      <= '0;
         last_ms_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
         // accepted log: advance the count and remember its time
         if (state_ff == ST_LOG_WR) begin
            total_ff   <= total_ff + TIME_W'(1);
            last_ms_ff <= req_ff.now_ms;
         end
         if (state_ff == ST_PG_SETUP) begin
            pend_valid_ff <= 1'b0;
         end else if (state_ff == ST_PG_DATA && hit) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      // command transfer
      if (state_ff == ST_IDLE && start) begin
         req_ff    <= req_data;
         rows_ff   <= rows_clamped;
         res_ok_ff <= 1'b0;
      end
      // partial products of the seconds conversion
      if (state_ff == ST_LOG_CHK) begin
         pl_ff <= PROD_W'(req_ff.now_ms[HALF_W-1:0]) * PROD_W'(DIV1000_MAGIC);
         ph_ff <= PROD_W'(req_ff.now_ms[TIME_W-1:HALF_W]) * PROD_W'(DIV1000_MAGIC);
      end
      if (state_ff == ST_LOG_WR) begin
         res_ok_ff    <= 1'b1;
         res_stamp_ff <= stamp_now;
         res_value_ff <= req_ff.sample_value;
      end
      // page count, one when the log is empty
      if (state_ff == ST_DIV_WAIT && div_done) begin
         pages_ff <= (avail == '0) ? COUNT_W'(1) : div_quot[COUNT_W-1:0];
      end
      // single record read result
      if (state_ff == ST_RD_DATA) begin
         res_ok_ff    <= hit;
         res_stamp_ff <= rd_rec.stamp;
         res_value_ff <= rd_rec.value;
      end
      if (state_ff == ST_RD_ADDR || (state_ff == ST_PG_ADDR && !page_stop)) begin
         rd_tag_ff <= rd_tag_in;
      end
      // page walk
      if (state_ff == ST_PG_SETUP) begin
         base_ff <= (BASE_W'(page_clamped) - BASE_W'(1)) * BASE_W'(rows_ff);
         row_ff  <= '0;
      end
      if (state_ff == ST_PG_ADDR && !page_stop) begin
         row_ff <= row_ff + ROWS_W'(1);
      end
      if (state_ff == ST_PG_DATA && hit) begin
         pend_stamp_ff <= rd_rec.stamp;
         pend_value_ff <= rd_rec.value;
      end
      // result transfer register
      if (emit) begin
         rsp_ff.ok              <= emit_ok;
         rsp_ff.stamp_seconds   <= emit_ok ? emit_stamp : '0;
         rsp_ff.record_value    <= emit_ok ? emit_value : '0;
         rsp_ff.available_count <= avail;
         rsp_ff.pages_total     <= pages_ff;
         rsp_ff.final_row       <= emit_final;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sectored history ring store: log, record and
// page commands against an in-bench model of the ring, across several log
// periods, sender idle patterns and a dense logging burst.
// ----------------------------------------------------------------------------
module tb;
   import shs_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_CAP  = 100;
   localparam int TAIL_CYCLES = 60;
   localparam int unsigned MS_PER_S = 1000;

   logic           clock;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   req_type        req_data = '0;
   logic           rsp_strobe;
   rsp_type        rsp_data;
   logic           csr_we = 1'b0;
   logic [TIME_W-1:0] csr_wdata = '0;

   // stimulus and expectations
   req_type        cmd_queue[$];
   rsp_type        rsp_expected[$];
   int             idle_pct = 0;
   int             fail_count = 0;
   int             cycle_count = 0;
   logic [TIME_W-1:0] gen_now;

   // model of the ring
   logic [STAMP_W-1:0] hist_stamp[STORE_DEPTH];
   logic [VALUE_W-1:0] hist_value[STORE_DEPTH];
   bit                 hist_live[STORE_DEPTH];
   logic [TIME_W-1:0]  logged_total;
   logic [TIME_W-1:0]  last_accept_ms;
   logic [TIME_W-1:0]  period_ms;

   sectored_history_ring_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // ring model
   // ------------------------------------------------------------------------
   function automatic int unsigned held_count();
      return (logged_total > RING_CAPACITY) ? RING_CAPACITY : logged_total;
   endfunction

   function automatic int unsigned page_span(int unsigned rows);
      int unsigned a;
      a = held_count();
      return (a == 0) ? 1 : (a + rows - 1) / rows;
   endfunction

   function automatic int unsigned slot_for(int unsigned g);
      return ((g / RECORDS_PER_SECTOR) % SECTOR_COUNT) * RECORDS_PER_SECTOR
             + g % RECORDS_PER_SECTOR;
   endfunction

   // record counted from the oldest; 0 when out of range or not valid
   function automatic bit fetch_record(int unsigned idx, output logic [STAMP_W-1:0] st,
                                       output logic [VALUE_W-1:0] v);
      int unsigned a;
      int unsigned s;
      a = held_count();
      st = '0;
      v = '0;
      if (idx >= a) return 1'b0;
      s = slot_for(logged_total - a + idx);
      if (!hist_live[s]) return 1'b0;
      st = hist_stamp[s];
      v = hist_value[s];
      return 1'b1;
   endfunction

   function automatic rsp_type make_rsp(bit ok, logic [STAMP_W-1:0] st,
                                        logic [VALUE_W-1:0] v, int unsigned rows, bit last);
      rsp_type t;
      t.ok              = ok;
      t.stamp_seconds   = ok ? st : '0;
      t.record_value    = ok ? v : '0;
      t.available_count = COUNT_W'(held_count());
      t.pages_total     = COUNT_W'(page_span(rows));
      t.final_row       = last;
      return t;
   endfunction

   // expected results of one accepted command
   function automatic void predict_command(req_type r);
      int unsigned rows;
      int unsigned g;
      int unsigned s;
      int unsigned a;
      int unsigned pc;
      int unsigned pg;
      int unsigned back;
      logic [TIME_W-1:0]  gap;
      logic [STAMP_W-1:0] st;
      logic [VALUE_W-1:0] v;
      rsp_type            rows_out[$];
      rsp_type            t;
      rows = 32'(r.rows_per_page);
      if (rows == 0) rows = 1;
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      case (r.opcode)
         OP_LOG: begin
            gap = r.now_ms - last_accept_ms;
            if (logged_total != 0 && gap < period_ms) begin
               rsp_expected.push_back(make_rsp(1'b0, '0, '0, rows, 1'b1));
            end else begin
               last_accept_ms = r.now_ms;
               g = logged_total;
               s = slot_for(g);
               // first record of a sector wipes the sector
               if (g % RECORDS_PER_SECTOR == 0) begin
                  for (int i = 0; i < RECORDS_PER_SECTOR; i++) hist_live[s + i] = 1'b0;
               end
               st = STAMP_W'(r.now_ms / MS_PER_S);
               hist_stamp[s] = st;
               hist_value[s] = r.sample_value;
               hist_live[s] = 1'b1;
               logged_total = g + 1;
               rsp_expected.push_back(make_rsp(1'b1, st, r.sample_value, rows, 1'b1));
            end
         end
         OP_READ: begin
            t = make_rsp(fetch_record(32'(r.record_index), st, v), st, v, rows, 1'b1);
            t.stamp_seconds = t.ok ? st : '0;
            t.record_value = t.ok ? v : '0;
            rsp_expected.push_back(t);
         end
         OP_PAGE: begin
            a = held_count();
            pc = page_span(rows);
            pg = 32'(r.page_number);
            if (pg < 1) pg = 1;
            if (pg > pc) pg = pc;
            // newest first, stop at page end, oldest record or a dead slot
            if (a > 0) begin
               for (int unsigned k = 0; k < rows; k++) begin
                  back = (pg - 1) * rows + k;
                  if (back >= a) break;
                  if (!fetch_record(a - 1 - back, st, v)) break;
                  rows_out.push_back(make_rsp(1'b1, st, v, rows, 1'b0));
               end
            end
            if (rows_out.size() == 0) begin
               rsp_expected.push_back(make_rsp(1'b0, '0, '0, rows, 1'b1));
            end else begin
               rows_out[rows_out.size() - 1].final_row = 1'b1;
               foreach (rows_out[k]) rsp_expected.push_back(rows_out[k]);
            end
         end
         default: begin
            rsp_expected.push_back(make_rsp(1'b0, '0, '0, rows, 1'b1));
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // command builders
   // ------------------------------------------------------------------------
   function automatic req_type noise_req();
      req_type t;
      t.opcode        = OPCODE_W'($urandom_range(0, 3));
      t.sample_value  = VALUE_W'($urandom_range(0, 65535));
      t.now_ms        = $urandom();
      t.record_index  = INDEX_W'($urandom_range(0, 2047));
      t.page_number   = PAGE_W'($urandom_range(0, 65535));
      t.rows_per_page = ROWS_W'($urandom_range(0, 31));
      return t;
   endfunction

   function automatic req_type log_req(logic [TIME_W-1:0] now, logic [VALUE_W-1:0] v);
      req_type t;
      t = noise_req();
      t.opcode = OP_LOG;
      t.now_ms = now;
      t.sample_value = v;
      return t;
   endfunction

   function automatic req_type read_req(logic [INDEX_W-1:0] idx);
      req_type t;
      t = noise_req();
      t.opcode = OP_READ;
      t.record_index = idx;
      return t;
   endfunction

   function automatic req_type page_req(logic [PAGE_W-1:0] pg, logic [ROWS_W-1:0] rows);
      req_type t;
      t = noise_req();
      t.opcode = OP_PAGE;
      t.page_number = pg;
      t.rows_per_page = rows;
      return t;
   endfunction

   // log time around the throttle window, tracked by gen_now
   function automatic req_type gen_log();
      logic [TIME_W-1:0] t;
      case ($urandom_range(0, 7))
         0: t = $urandom();
         1: t = gen_now + $urandom_range(0, period_ms - 1);
         2: t = gen_now + period_ms - 1;
         3: t = gen_now - 1;
         default: t = gen_now + period_ms + $urandom_range(0, 2);
      endcase
      if (t - gen_now >= period_ms) gen_now = t;
      return log_req(t, VALUE_W'($urandom_range(0, 65535)));
   endfunction

   function automatic void add_random(int n);
      int unsigned est;
      int k;
      logic [ROWS_W-1:0] rows;
      logic [PAGE_W-1:0] pg;
      logic [INDEX_W-1:0] idx;
      est = held_count();
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            cmd_queue.push_back(gen_log());
         end else if (k < 70) begin
            case ($urandom_range(0, 3))
               0: idx = INDEX_W'($urandom_range(0, 2047));
               1: idx = '0;
               2: idx = INDEX_W'($urandom_range(0, (est > 0) ? est - 1 : 0));
               default: idx = INDEX_W'(est + $urandom_range(0, 2) - 1);
            endcase
            cmd_queue.push_back(read_req(idx));
         end else if (k < 95) begin
            case ($urandom_range(0, 9))
               0, 1: rows = $urandom_range(0, 1) ? 5'd0 : ROWS_W'($urandom_range(17, 31));
               default: rows = ROWS_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 4))
               0: pg = '0;
               1: pg = PAGE_W'($urandom_range(0, 65535));
               2: pg = PAGE_W'($urandom_range(1, 200));
               default: pg = PAGE_W'($urandom_range(1, 4));
            endcase
            cmd_queue.push_back(page_req(pg, rows));
         end else begin
            cmd_queue.push_back(noise_req());
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // driver: one command per transfer, random sender gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_data <= cmd_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check results first, then book the command taken at this edge
   // ------------------------------------------------------------------------
   task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", label, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (rsp_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_CAP) $error("result transfer with nothing expected");
            end else begin
               want = rsp_expected.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
               check_field("stamp_seconds", 32'(want.stamp_seconds),
                           32'(rsp_data.stamp_seconds));
               check_field("record_value", 32'(want.record_value),
                           32'(rsp_data.record_value));
               check_field("available_count", 32'(want.available_count),
                           32'(rsp_data.available_count));
               check_field("pages_total", 32'(want.pages_total),
                           32'(rsp_data.pages_total));
               check_field("final_row", 32'(want.final_row), 32'(rsp_data.final_row));
            end
         end
         if (start && busy === 1'b0) predict_command(req_data);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   task automatic wait_idle();
      @(negedge clock);
      while (cmd_queue.size() != 0 || start || busy !== 1'b0 || rsp_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_period(logic [TIME_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      period_ms = v;
      gen_now = last_accept_ms;
      @(negedge clock);
   endtask

   initial begin
      foreach (hist_live[i]) hist_live[i] = 1'b0;
      logged_total = '0;
      last_accept_ms = '0;
      period_ms = PERIOD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty store, throttle edges around the reset period, page clamps
      idle_pct = 0;
      cmd_queue.push_back(read_req('0));
      cmd_queue.push_back(page_req('0, '0));
      cmd_queue.push_back(log_req('0, '0));
      cmd_queue[2].opcode = OP_SPARE;
      cmd_queue.push_back(log_req(32'hFFFF_FFFF, 16'hFFFF));
      cmd_queue.push_back(log_req(32'd499, 16'd1));
      cmd_queue.push_back(log_req(32'd998, 16'd2));
      cmd_queue.push_back(log_req(32'd999, 16'd0));
      cmd_queue.push_back(log_req(32'd1999, 16'h8000));
      cmd_queue.push_back(log_req(32'd2998, 16'd3));
      cmd_queue.push_back(log_req(32'd3000, 16'h00FF));
      for (int i = 0; i < 5; i++) cmd_queue.push_back(read_req(INDEX_W'(i)));
      cmd_queue.push_back(read_req(11'd2047));
      cmd_queue.push_back(page_req(16'hFFFF, 5'd31));
      cmd_queue.push_back(page_req(16'd1, 5'd1));
      cmd_queue.push_back(page_req(16'd2, 5'd3));
      cmd_queue.push_back(page_req(16'd3, 5'd1));
      cmd_queue.push_back(page_req(16'd2, 5'd16));
      cmd_queue.push_back(page_req(16'd1, 5'd17));
      wait_idle();

      // shortest period, no gaps
      write_period(32'd1);
      add_random(30);
      wait_idle();

      // mid period, sparse sender
      write_period($urandom_range(2, 5000));
      idle_pct = 61;
      add_random(30);
      wait_idle();

      // longest period: only a log one tick behind the last one gets in
      write_period(32'hFFFF_FFFF);
      idle_pct = 30;
      cmd_queue.push_back(log_req(gen_now + 5, VALUE_W'($urandom_range(0, 65535))));
      cmd_queue.push_back(log_req(gen_now - 1, VALUE_W'($urandom_range(0, 65535))));
      cmd_queue.push_back(log_req(gen_now - 1, VALUE_W'($urandom_range(0, 65535))));
      gen_now = gen_now - 1;
      add_random(15);
      wait_idle();

      // dense logging burst with reads and pages mixed in
      write_period(32'd1);
      for (int i = 0; i < 50; i++) begin
         int k;
         k = $urandom_range(0, 99);
         if (k < 88) begin
            gen_now = gen_now + $urandom_range(1, 3);
            cmd_queue.push_back(log_req(gen_now, VALUE_W'($urandom_range(0, 65535))));
         end else if (k < 91) begin
            cmd_queue.push_back(log_req(gen_now, VALUE_W'($urandom_range(0, 65535))));
         end else if (k < 95) begin
            cmd_queue.push_back(read_req(INDEX_W'($urandom_range(0, 2047))));
         end else begin
            cmd_queue.push_back(page_req(PAGE_W'($urandom_range(0, 4)),
                                         ROWS_W'($urandom_range(0, 31))));
         end
      end
      wait_idle();

      // reset period again, sparse sender, reads and pages past the end
      write_period(PERIOD_RESET);
      idle_pct = 61;
      add_random(15);
      cmd_queue.push_back(read_req(11'd1535));
      cmd_queue.push_back(read_req(11'd1536));
      cmd_queue.push_back(page_req(16'd1536, 5'd1));
      cmd_queue.push_back(page_req(16'd96, 5'd16));
      wait_idle();

      // random period
      write_period($urandom());
      idle_pct = 0;
      add_random(10);
      wait_idle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
